[src/aes128_pkg.sv]
package aes128_pkg;

    localparam int unsigned BLOCK_W = 128;
    localparam int unsigned HALF_W  = 64;
    localparam int unsigned NUM_ROUNDS = 10;

    // Round constant of the first round and of the last round, high byte only.
    localparam logic [7:0] RCON_FIRST = 8'h01;
    localparam logic [7:0] RCON_LAST  = 8'h36;
    localparam logic [7:0] GF_POLY    = 8'h1b;

    typedef enum logic {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_reg_idx;

    // One item as it travels down the round chain.
    typedef struct packed {
        logic                 valid;
        logic [BLOCK_W-1:0]   state;
        logic [BLOCK_W-1:0]   rkey;
        logic [7:0]           rcon;
    } t_stage;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,
        8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,
        8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,
        8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,
        8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,
        8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,
        8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,
        8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,
        8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,
        8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,
        8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,
        8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,
        8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,
        8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,
        8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,
        8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,
        8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] sbox(input logic [7:0] x);
        return SBOX[x];
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] w);
        return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
    endfunction

endpackage

[src/aes128_round_cell.sv]
module aes128_round_cell
    import aes128_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_stage i_stage,
    output t_stage o_stage
);

    logic [31:0]        w_in   [4];
    logic [31:0]        w_key  [4];
    logic [31:0]        w_sub  [4];
    logic [31:0]        w_mix  [4];
    logic [31:0]        w_temp;
    logic               last_round;
    logic [7:0]         a0, a1, a2, a3;
    logic [BLOCK_W-1:0] n_state;
    logic [BLOCK_W-1:0] n_rkey;
    t_stage             r_stage;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_in[c]  = i_stage.state[BLOCK_W-1-32*c -: 32];
            w_key[c] = i_stage.rkey[BLOCK_W-1-32*c -: 32];
        end

        // Next round key: rotate, substitute and add the round constant on the last word.
        w_temp = sub_word({w_key[3][23:0], w_key[3][31:24]}) ^ {i_stage.rcon, 24'h000000};
        n_rkey[127:96] = w_key[0] ^ w_temp;
        n_rkey[95:64]  = w_key[1] ^ n_rkey[127:96];
        n_rkey[63:32]  = w_key[2] ^ n_rkey[95:64];
        n_rkey[31:0]   = w_key[3] ^ n_rkey[63:32];

        // Row r of column c comes from column (c + r) mod 4.
        for (int c = 0; c < 4; c++) begin
            w_sub[c] = {sbox(w_in[c][31:24]),
                        sbox(w_in[(c + 1) % 4][23:16]),
                        sbox(w_in[(c + 2) % 4][15:8]),
                        sbox(w_in[(c + 3) % 4][7:0])};
        end

        a0 = 8'h00;
        a1 = 8'h00;
        a2 = 8'h00;
        a3 = 8'h00;
        for (int c = 0; c < 4; c++) begin
            a0 = w_sub[c][31:24];
            a1 = w_sub[c][23:16];
            a2 = w_sub[c][15:8];
            a3 = w_sub[c][7:0];
            w_mix[c] = {xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3,
                        a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3,
                        a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3,
                        xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3)};
        end

        // The final round skips MixColumns; its round constant marks it.
        last_round = (i_stage.rcon == RCON_LAST);
        for (int c = 0; c < 4; c++) begin
            n_state[BLOCK_W-1-32*c -: 32] = (last_round ? w_sub[c] : w_mix[c])
                                            ^ n_rkey[BLOCK_W-1-32*c -: 32];
        end
    end

    always_ff @(posedge i_clk) begin
        r_stage.state <= n_state;
        r_stage.rkey  <= n_rkey;
        r_stage.rcon  <= xtime(i_stage.rcon);
        if (!i_rst_n) begin
            r_stage.valid <= 1'b0;
        end else begin
            r_stage.valid <= i_stage.valid;
        end
    end

    assign o_stage = r_stage;

endmodule

[src/aes128_block_encrypt.sv]
// AES-128 encryption, one 128-bit block per item, one item accepted in every
// clock cycle (busy is never raised). Each block passes the initial key
// addition register and then a chain of ten round cells, one per AES round,
// each of which also derives its round key from the one handed down by its
// neighbor. The ciphertext appears with o_valid once its block has left the
// last round cell, in acceptance order; the receiver cannot stall the chain,
// so it must take every strobed result. The key registers are read only at
// acceptance and the key travels down the chain with its block, so a key
// write affects only blocks accepted after it.
module aes128_block_encrypt
    import aes128_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [HALF_W-1:0]  i_block_high,
    input  logic [HALF_W-1:0]  i_block_low,
    input  logic               i_cfg_we,
    input  logic               i_cfg_idx,
    input  logic [HALF_W-1:0]  i_cfg_data,
    output logic               o_valid,
    output logic [HALF_W-1:0]  o_cipher_high,
    output logic [HALF_W-1:0]  o_cipher_low
);

    logic [HALF_W-1:0] r_key_high;
    logic [HALF_W-1:0] r_key_low;
    t_stage            r_first;
    t_stage            chain [NUM_ROUNDS+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_KEY_HIGH: r_key_high <= i_cfg_data;
                REG_KEY_LOW:  r_key_low  <= i_cfg_data;
                default:      r_key_low  <= r_key_low;
            endcase
        end
    end

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        r_first.state <= {i_block_high, i_block_low} ^ {r_key_high, r_key_low};
        r_first.rkey  <= {r_key_high, r_key_low};
        r_first.rcon  <= RCON_FIRST;
        if (!i_rst_n) begin
            r_first.valid <= 1'b0;
        end else begin
            r_first.valid <= start & ~busy;
        end
    end

    assign chain[0] = r_first;

    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        aes128_round_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (chain[g]),
            .o_stage (chain[g+1])
        );
    end

    assign o_valid       = chain[NUM_ROUNDS].valid;
    assign o_cipher_high = chain[NUM_ROUNDS].state[BLOCK_W-1:HALF_W];
    assign o_cipher_low  = chain[NUM_ROUNDS].state[HALF_W-1:0];

endmodule
